// File: sv/mrls_pkg.sv
// ----------------------------------------------------------------------------
// mrls_pkg
// Shared types and constants for the multiplexed RGB LED scanner: command
// codes, register indexes, transfer payloads and controller/datapath links.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrls_pkg;

  // Command codes carried in the input item
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_SET     = 2'd1,
    CMD_ALL_OFF = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic CFG_BRIGHTNESS = 1'b0;
  localparam logic CFG_LED_COUNT  = 1'b1;

  localparam int unsigned CfgDataW = 7;

  // Brightness scaling: full scale percent, top level, and a reciprocal of
  // the percent divisor that is exact for products below 43690
  localparam logic [6:0]  PCT_FULL    = 7'd100;
  localparam logic [7:0]  LVL_MAX     = 8'd255;
  localparam int unsigned ProdW       = 15;
  localparam int unsigned RecipW      = 13;
  localparam logic [12:0] RECIP_MUL   = 13'd5243;
  localparam int unsigned RecipShift  = 19;
  localparam int unsigned ScaledW     = ProdW + RecipW;

  // Input item
  typedef struct packed {
    logic [1:0] command;
    logic [3:0] led_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [2:0] drive_index;
    logic [7:0] drive_red;
    logic [7:0] drive_green;
    logic [7:0] drive_blue;
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
    logic       read_valid;
  } out_item_t;

  // Controller state codes, one-hot
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_MOD    = 8'b0000_0100,
    S_TFETCH = 8'b0000_1000,
    S_RFETCH = 8'b0001_0000,
    S_MUL1   = 8'b0010_0000,
    S_MUL2   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic mod_step;
    logic mod_commit;
    logic read_issue;
    logic load_drive;
    logic load_read;
    logic mul_stage;
    logic write_entry;
    logic clear_all;
    logic emit;
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic idx_in_range;
    logic mod_ge;
  } stat_t;

endpackage

// File: sv/mrls_ram.sv
// ----------------------------------------------------------------------------
// mrls_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrls_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/mrls_ctrl.sv
// ----------------------------------------------------------------------------
// mrls_ctrl
// Controller for the LED scanner: sequences one command at a time through
// decode, scan reduction, store access, scaling and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrls_ctrl import mrls_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.cmd)
          CMD_TICK: begin
            state_d = S_MOD;
          end
          CMD_SET: begin
            state_d = stat_i.idx_in_range ? S_MUL1 : S_DONE;
          end
          CMD_ALL_OFF: begin
            ctrl_o.clear_all = 1'b1;
            state_d          = S_DONE;
          end
          CMD_READ: begin
            if (stat_i.idx_in_range) begin
              ctrl_o.read_issue = 1'b1;
              state_d           = S_RFETCH;
            end else begin
              state_d = S_DONE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_MOD: begin
        // Subtract the count until the next position falls in range
        if (stat_i.mod_ge) begin
          ctrl_o.mod_step = 1'b1;
        end else begin
          ctrl_o.mod_commit = 1'b1;
          state_d           = S_TFETCH;
        end
      end
      S_TFETCH: begin
        ctrl_o.load_drive = 1'b1;
        state_d           = S_DONE;
      end
      S_RFETCH: begin
        ctrl_o.load_read = 1'b1;
        state_d          = S_DONE;
      end
      S_MUL1: begin
        ctrl_o.mul_stage = 1'b1;
        state_d          = S_MUL2;
      end
      S_MUL2: begin
        ctrl_o.write_entry = 1'b1;
        state_d            = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          ctrl_o.emit = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register occupancy: set on emit, drop on transfer
  assign out_valid_d = ctrl_o.emit | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: sv/mrls_dpath.sv
// ----------------------------------------------------------------------------
// mrls_dpath
// Datapath for the LED scanner: configuration registers, scan position,
// drive levels, colour store with valid bits, brightness scaling and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrls_dpath import mrls_pkg::*; #(
  parameter int unsigned MAX_LEDS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_item_t            in_data_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  ctrl_t               ctrl_i,
  output stat_t               stat_o,
  output out_item_t           out_data_o
);

  // Largest usable count: bounded by the store and by the 4-bit count field
  localparam int unsigned CntMaxInt = (MAX_LEDS < 15) ? MAX_LEDS : 15;
  localparam logic [3:0]  CNT_MAX   = 4'(CntMaxInt);
  localparam int unsigned PW        = (CntMaxInt > 1) ? $clog2(CntMaxInt) : 1;
  localparam int unsigned AW        = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  // Configuration
  logic [6:0] brightness_q;
  logic [3:0] led_count_q;
  logic [3:0] count_eff;
  logic [6:0] bright_eff;

  // Command context
  cmd_e            cmd_q;
  logic [3:0]      idx_q;
  logic [2:0][7:0] rgb_q;

  // Scan and drive state
  logic [PW-1:0]   pos_q;
  logic [3:0]      temp_q;
  logic [23:0]     drive_q;
  logic [23:0]     rd_q;
  logic            rd_valid_q;
  logic [3:0]      pos_ext;

  // Store
  logic [MAX_LEDS-1:0] vld_q;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       rd_addr_q;
  logic [23:0]         rdata;
  logic [23:0]         entry;
  logic [AW-1:0]       waddr;

  // Scaling
  logic [2:0][ProdW-1:0] prod_q;
  logic [2:0][7:0]       scaled;
  logic [23:0]           wdata;

  out_item_t out_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= PCT_FULL;
      led_count_q  <= 4'd8;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_BRIGHTNESS) begin
        brightness_q <= cfg_data_i[6:0];
      end
      if (cfg_index_i == CFG_LED_COUNT) begin
        led_count_q <= cfg_data_i[3:0];
      end
    end
  end

  // Clamp count and brightness to their usable ranges
  always_comb begin
    if (led_count_q == 4'd0) begin
      count_eff = 4'd1;
    end else if (led_count_q > CNT_MAX) begin
      count_eff = CNT_MAX;
    end else begin
      count_eff = led_count_q;
    end
    bright_eff = (brightness_q > PCT_FULL) ? PCT_FULL : brightness_q;
  end

  // Hold the accepted command
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q    <= cmd_e'(in_data_i.command);
      idx_q    <= in_data_i.led_index;
      rgb_q[2] <= in_data_i.red_in;
      rgb_q[1] <= in_data_i.green_in;
      rgb_q[0] <= in_data_i.blue_in;
    end
  end

  // Next scan position: start at position plus one, reduce by the count
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      temp_q <= 4'(pos_q) + 4'd1;
    end else if (ctrl_i.mod_step) begin
      temp_q <= temp_q - count_eff;
    end
  end

  assign stat_o.cmd          = cmd_q;
  assign stat_o.idx_in_range = (idx_q < count_eff);
  assign stat_o.mod_ge       = (temp_q >= count_eff);

  // Store read address: scan target on a tick, addressed LED on a read
  assign raddr = ctrl_i.mod_commit ? AW'(temp_q) : AW'(idx_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mod_commit || ctrl_i.read_issue) begin
      rd_addr_q <= raddr;
    end
  end

  // An entry never written since reset or all-off reads as zero
  assign entry = vld_q[rd_addr_q] ? rdata : 24'd0;

  // Scale each channel: product, then divide by the percent via reciprocal
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [ScaledW-1:0] full;
      logic [8:0]         lvl;
      full = ScaledW'(prod_q[k]) * ScaledW'(RECIP_MUL);
      lvl  = 9'(full >> RecipShift);
      if (rgb_q[k] != 8'd0 && rgb_q[k] != LVL_MAX) begin
        lvl = lvl + 9'd1;
      end
      scaled[k] = (lvl > 9'(LVL_MAX)) ? LVL_MAX : lvl[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_stage) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= ProdW'(rgb_q[k]) * ProdW'(bright_eff);
      end
    end
  end

  assign wdata = {scaled[2], scaled[1], scaled[0]};
  assign waddr = AW'(idx_q);

  mrls_ram #(
    .WIDTH (24),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.write_entry),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctrl_i.mod_commit | ctrl_i.read_issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Scan position, drive levels and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      drive_q <= '0;
      vld_q   <= '0;
    end else begin
      if (ctrl_i.mod_commit) begin
        pos_q <= PW'(temp_q);
      end
      if (ctrl_i.clear_all) begin
        vld_q   <= '0;
        drive_q <= '0;
      end else begin
        if (ctrl_i.load_drive) begin
          drive_q <= entry;
        end
        if (ctrl_i.write_entry) begin
          vld_q[waddr] <= 1'b1;
        end
      end
    end
  end

  // Read-back colour, cleared for every new command
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      rd_q       <= '0;
      rd_valid_q <= 1'b0;
    end else if (ctrl_i.load_read) begin
      rd_q       <= entry;
      rd_valid_q <= 1'b1;
    end
  end

  assign pos_ext = 4'(pos_q);

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      out_q.drive_index <= pos_ext[2:0];
      out_q.drive_red   <= drive_q[23:16];
      out_q.drive_green <= drive_q[15:8];
      out_q.drive_blue  <= drive_q[7:0];
      out_q.read_red    <= rd_q[23:16];
      out_q.read_green  <= rd_q[15:8];
      out_q.read_blue   <= rd_q[7:0];
      out_q.read_valid  <= rd_valid_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// File: sv/multiplexed_rgb_led_scanner.sv
// ----------------------------------------------------------------------------
// multiplexed_rgb_led_scanner
// Time-multiplexed driver for a bank of common-anode RGB LEDs sharing one
// set of PWM levels, with a brightness-scaled colour store per LED.
// ----------------------------------------------------------------------------
// Commands are handled one at a time, each giving one result transfer. After
// decode, all-off or an out-of-range set or read goes straight to the done
// state, an in-range read passes through a fetch state, an in-range set
// through two multiply stages, and a tick through the reduction state, where
// it makes the count subtractions needed to wrap the scan position (none for
// a plain step to the next LED, one when the scan wraps back to LED zero,
// more only after the LED count was lowered below the current position), then
// a fetch state. The colour store is a RAM with one read port and registered
// read data, so each store read goes through a fetch state. A finished
// result waits in the output register; the block goes back to idle once
// it is loaded. Writes to brightness (index 0) and LED count (index 1) are
// always accepted and must only be issued while the block is idle.
`timescale 1ns / 1ps

module multiplexed_rgb_led_scanner import mrls_pkg::*; #(
  parameter int unsigned MAX_LEDS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  ctrl_t ctrl;
  stat_t stat;

  // Configuration writes never wait
  assign cfg_ready_o = 1'b1;

  mrls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  mrls_dpath #(
    .MAX_LEDS (MAX_LEDS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/multiplexed_rgb_led_scanner_tb.sv
// ----------------------------------------------------------------------------
// multiplexed_rgb_led_scanner_tb
// Self-checking bench for the LED scanner. A monitor predicts every result
// from the accepted commands and register writes, and a checker compares
// each result transfer with the oldest prediction. Directed tests cover the
// reset state, scaling extremes, out-of-range indexes and the scan wrap
// when the LED count shrinks. Random phases follow, under several register
// settings, with random gaps on the command side and random stalls on the
// result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multiplexed_rgb_led_scanner_tb;
  import mrls_pkg::*;

  localparam int unsigned NumLeds   = 8;
  localparam int unsigned SettleCyc = 24;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Predicted scanner state
  logic [23:0]  led_colour_q [NumLeds];
  int unsigned  scan_pos_q;
  logic [23:0]  pwm_level_q;
  logic [6:0]   pct_q;
  logic [3:0]   count_q;

  out_item_t    pending_results[$];
  int unsigned  error_count;
  int unsigned  results_checked;
  int unsigned  cfg_writes;
  int unsigned  cmd_seen [4];

  // Idling knobs, in percent
  int unsigned  gap_pct;
  int unsigned  stall_pct;
  int unsigned  stall_left;

  multiplexed_rgb_led_scanner #(
    .MAX_LEDS(NumLeds)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock: 4 ns period
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Scale one channel by the panel percent
  function automatic logic [7:0] scale_level(input logic [7:0] lvl, input logic [6:0] pct);
    int unsigned p;
    int unsigned v;
    p = (pct > PCT_FULL) ? PCT_FULL : pct;
    v = (int'(lvl) * p) / int'(PCT_FULL);
    if (lvl != 8'd0 && lvl != LVL_MAX) v++;
    if (v > LVL_MAX) v = LVL_MAX;
    return v[7:0];
  endfunction

  function automatic int unsigned live_leds();
    int unsigned n;
    n = count_q;
    if (n < 1) n = 1;
    if (n > NumLeds) n = NumLeds;
    return n;
  endfunction

  // Apply one command to the predicted state and build its result
  task automatic apply_command(input in_item_t c, output out_item_t r);
    int unsigned n;
    logic [23:0] rd;
    n  = live_leds();
    rd = '0;
    r  = '0;
    case (cmd_e'(c.command))
      CMD_TICK: begin
        scan_pos_q  = (scan_pos_q + 1) % n;
        pwm_level_q = led_colour_q[scan_pos_q % NumLeds];
      end
      CMD_SET: begin
        if (c.led_index < n) begin
          led_colour_q[c.led_index % NumLeds] = {scale_level(c.red_in, pct_q),
                                                 scale_level(c.green_in, pct_q),
                                                 scale_level(c.blue_in, pct_q)};
        end
      end
      CMD_ALL_OFF: begin
        foreach (led_colour_q[i]) led_colour_q[i] = '0;
        pwm_level_q = '0;
      end
      default: begin
        if (c.led_index < n) begin
          rd           = led_colour_q[c.led_index % NumLeds];
          r.read_valid = 1'b1;
        end
      end
    endcase
    r.drive_index = scan_pos_q[2:0];
    r.drive_red   = pwm_level_q[23:16];
    r.drive_green = pwm_level_q[15:8];
    r.drive_blue  = pwm_level_q[7:0];
    r.read_red    = rd[23:16];
    r.read_green  = rd[15:8];
    r.read_blue   = rd[7:0];
  endtask

  // Track register writes and accepted commands
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t r;
    if (!rst_ni) begin
      foreach (led_colour_q[i]) led_colour_q[i] = '0;
      scan_pos_q  = 0;
      pwm_level_q = '0;
      pct_q       = PCT_FULL;
      count_q     = 4'd8;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_BRIGHTNESS) pct_q = cfg_data_i;
        else count_q = cfg_data_i[3:0];
        cfg_writes++;
      end
      if (in_valid_i && !in_stall_o) begin
        apply_command(in_data_i, r);
        pending_results.push_back(r);
        cmd_seen[in_data_i.command]++;
      end
    end
  end

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected, actual %h", $time, out_data_o);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        report_field("drive_index", want.drive_index, out_data_o.drive_index);
        report_field("drive_red", want.drive_red, out_data_o.drive_red);
        report_field("drive_green", want.drive_green, out_data_o.drive_green);
        report_field("drive_blue", want.drive_blue, out_data_o.drive_blue);
        report_field("read_red", want.read_red, out_data_o.read_red);
        report_field("read_green", want.read_green, out_data_o.read_green);
        report_field("read_blue", want.read_blue, out_data_o.read_blue);
        report_field("read_valid", want.read_valid, out_data_o.read_valid);
      end
    end
  end

  // Result-side stalls: mostly short bursts, a few long ones
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(99) >= gap_pct) return 0;
    return ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
  endfunction

  // Send one command, then hold off for a random gap
  task automatic drive_command(input in_item_t item);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic in_item_t make_command(input cmd_e cmd, input int unsigned idx,
                                            input int unsigned r, input int unsigned g,
                                            input int unsigned b);
    in_item_t c;
    c.command   = cmd;
    c.led_index = idx[3:0];
    c.red_in    = r[7:0];
    c.green_in  = g[7:0];
    c.blue_in   = b[7:0];
    return c;
  endfunction

  // Drop valid and wait until every predicted result has arrived
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write both registers; junk in the unused upper count bits
  task automatic set_panel(input int unsigned pct, input int unsigned leds);
    settle();
    write_register(CFG_BRIGHTNESS, pct[6:0]);
    write_register(CFG_LED_COUNT, {3'($urandom_range(7)), leds[3:0]});
  endtask

  function automatic int unsigned random_level();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 255;
      2:       return 1;
      3:       return 254;
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic in_item_t random_command();
    int unsigned pick;
    int unsigned idx;
    cmd_e        cmd;
    pick = $urandom_range(99);
    if (pick < 36)      cmd = CMD_TICK;
    else if (pick < 68) cmd = CMD_SET;
    else if (pick < 97) cmd = CMD_READ;
    else                cmd = CMD_ALL_OFF;
    idx = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(live_leds() - 1);
    return make_command(cmd, idx, random_level(), random_level(), random_level());
  endfunction

  // Reset state, scaling extremes, range checks and a full scan
  task automatic test_basic_commands();
    gap_pct   = 30;
    stall_pct = 20;
    drive_command(make_command(CMD_READ, 0, 0, 0, 0));
    drive_command(make_command(CMD_READ, 15, 255, 255, 255));
    drive_command(make_command(CMD_SET, 0, 255, 255, 255));
    drive_command(make_command(CMD_SET, 1, 1, 254, 0));
    drive_command(make_command(CMD_SET, 7, 128, 64, 32));
    drive_command(make_command(CMD_SET, 8, 9, 9, 9));
    drive_command(make_command(CMD_SET, 15, 200, 100, 50));
    drive_command(make_command(CMD_READ, 1, 0, 0, 0));
    drive_command(make_command(CMD_READ, 7, 0, 0, 0));
    drive_command(make_command(CMD_READ, 8, 0, 0, 0));
    repeat (8) drive_command(make_command(CMD_TICK, 0, 0, 0, 0));
    drive_command(make_command(CMD_ALL_OFF, 3, 17, 34, 51));
    drive_command(make_command(CMD_READ, 0, 0, 0, 0));
    drive_command(make_command(CMD_TICK, 0, 0, 0, 0));
    settle();
  endtask

  // Shrink the count below the scan position, then count zero
  task automatic test_scan_shrink();
    int unsigned steps;
    set_panel(100, 8);
    steps = 7 - scan_pos_q;
    drive_command(make_command(CMD_SET, 7, 10, 20, 30));
    drive_command(make_command(CMD_SET, 2, 40, 50, 60));
    repeat (steps) drive_command(make_command(CMD_TICK, 0, 0, 0, 0));
    set_panel(100, 3);
    drive_command(make_command(CMD_TICK, 0, 0, 0, 0));
    drive_command(make_command(CMD_SET, 3, 1, 1, 1));
    drive_command(make_command(CMD_READ, 2, 0, 0, 0));
    set_panel(100, 0);
    drive_command(make_command(CMD_TICK, 0, 0, 0, 0));
    drive_command(make_command(CMD_READ, 1, 0, 0, 0));
    drive_command(make_command(CMD_SET, 0, 255, 128, 1));
    drive_command(make_command(CMD_READ, 0, 0, 0, 0));
  endtask

  // Random commands under one panel setting
  task automatic run_random_phase(input int unsigned pct, input int unsigned leds,
                                  input int unsigned items, input int unsigned gaps,
                                  input int unsigned stalls, input bit pause_mid);
    set_panel(pct, leds);
    gap_pct   = gaps;
    stall_pct = stalls;
    for (int unsigned i = 0; i < items; i++) begin
      if (pause_mid && i == items / 2) settle();
      drive_command(random_command());
    end
  endtask

  task automatic test_random_settings();
    run_random_phase(0, 1, 170, 25, 25, 1'b1);
    run_random_phase(127, 15, 170, 30, 20, 1'b0);
    run_random_phase(1, 0, 170, 0, 0, 1'b0);
    run_random_phase(50, 4, 170, 40, 40, 1'b0);
    run_random_phase(99, 9, 170, 20, 30, 1'b1);
    run_random_phase(100, 8, 170, 30, 10, 1'b0);
    run_random_phase(73, 5, 170, 10, 50, 1'b0);
    repeat (3) begin
      run_random_phase($urandom_range(127), $urandom_range(15), 170, 25, 25, 1'b0);
    end
  endtask

  // Run the tests in turn and report
  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_BRIGHTNESS;
    cfg_data_i  <= '0;
    stall_left  <= 0;
    gap_pct     = 0;
    stall_pct   = 0;
    error_count = 0;
    results_checked = 0;
    cfg_writes  = 0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_commands();
    test_scan_shrink();
    test_random_settings();
    settle();

    $display("Covered %0d ticks, %0d sets, %0d all-off and %0d reads under %0d register writes;",
             cmd_seen[CMD_TICK], cmd_seen[CMD_SET], cmd_seen[CMD_ALL_OFF],
             cmd_seen[CMD_READ], cfg_writes);
    $display("%0d results checked, %0d mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("multiplexed_rgb_led_scanner_tb OK");
    end else begin
      $display("multiplexed_rgb_led_scanner_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("multiplexed_rgb_led_scanner_tb NOT OK");
    $finish;
  end

endmodule

// File: multiplexed_rgb_led_scanner.f
sv/mrls_pkg.sv
sv/mrls_ram.sv
sv/mrls_ctrl.sv
sv/mrls_dpath.sv
sv/multiplexed_rgb_led_scanner.sv
tb/multiplexed_rgb_led_scanner_tb.sv
